FILE: src/ddl_pkg.sv
package ddl_pkg;

	localparam int DEPTH_W     = 16;
	localparam int DISP_W      = 16;
	localparam int ENTRY_IDX_W = 11;
	localparam int CFG_W       = 12;
	localparam int FRAC_W      = 4;
	localparam int IDX_W       = 13;
	localparam int CFG_IDX_W   = 1;

	localparam logic [DISP_W:0] ROUND_HALF = (DISP_W + 1)'(8);

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_ROUND_NEAREST = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_ENTRIES = 1'b1;

	typedef struct packed {
		logic              hole;
		logic              interp;
		logic [FRAC_W-1:0] frac;
	} lookup_ctl_t;

endpackage

FILE: src/ddl_ifs.sv
interface ddl_req_if;
	import ddl_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   req_type;
	logic [ENTRY_IDX_W-1:0] entry_index;
	logic [DEPTH_W-1:0]     entry_value;
	logic [DISP_W-1:0]      disparity_q4;

	modport source (
		output valid, req_type, entry_index, entry_value, disparity_q4,
		input  ready
	);
	modport sink (
		input  valid, req_type, entry_index, entry_value, disparity_q4,
		output ready
	);
endinterface

interface ddl_rsp_if;
	import ddl_pkg::*;

	logic               valid;
	logic               ready;
	logic [DEPTH_W-1:0] depth_mm;

	modport source (
		output valid, depth_mm,
		input  ready
	);
	modport sink (
		input  valid, depth_mm,
		output ready
	);
endinterface

FILE: src/ddl_table_ram.sv
module ddl_table_ram #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [ddl_pkg::DEPTH_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr_a,
	input  logic [AW-1:0]               raddr_b,
	output logic [ddl_pkg::DEPTH_W-1:0] rdata_a,
	output logic [ddl_pkg::DEPTH_W-1:0] rdata_b
);
	import ddl_pkg::*;

	logic [DEPTH_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end
endmodule

FILE: src/ddl_addr_gen.sv
module ddl_addr_gen #(
	parameter int TABLE_DEPTH = 2048,
	parameter int AW          = 11
) (
	input  logic                       round_nearest,
	input  logic [ddl_pkg::CFG_W-1:0]  table_entries,
	input  logic [ddl_pkg::DISP_W-1:0] disparity_q4,
	output logic [AW-1:0]              raddr_a,
	output logic [AW-1:0]              raddr_b,
	output ddl_pkg::lookup_ctl_t       ctl
);
	import ddl_pkg::*;

	logic [IDX_W-1:0]  n;
	logic [IDX_W-1:0]  n_last;
	logic [IDX_W-1:0]  te_ext;
	logic [DISP_W:0]   rounded;
	logic [IDX_W-1:0]  idx_near;
	logic [IDX_W-1:0]  idx_int;
	logic [IDX_W-1:0]  idx_a;
	logic              at_last;

	always_comb begin
		te_ext   = IDX_W'(table_entries);
		n        = (te_ext > IDX_W'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH) : te_ext;
		n_last   = n - IDX_W'(1);
		rounded  = {1'b0, disparity_q4} + ROUND_HALF;
		idx_near = IDX_W'(rounded[DISP_W:FRAC_W]);
		idx_int  = IDX_W'(disparity_q4[DISP_W-1:FRAC_W]);
		at_last  = 1'b0;
		if (round_nearest) begin
			idx_a = (idx_near >= n) ? n_last : idx_near;
		end else begin
			at_last = (idx_int >= n_last);
			idx_a   = at_last ? n_last : idx_int;
		end
		raddr_a    = AW'(idx_a);
		raddr_b    = AW'(idx_int + IDX_W'(1));
		ctl.hole   = (disparity_q4 == '0) || (n == '0);
		ctl.interp = !round_nearest && !at_last;
		ctl.frac   = disparity_q4[FRAC_W-1:0];
	end
endmodule

FILE: src/ddl_interp.sv
module ddl_interp (
	input  logic [ddl_pkg::DEPTH_W-1:0] entry_a,
	input  logic [ddl_pkg::DEPTH_W-1:0] entry_b,
	input  ddl_pkg::lookup_ctl_t        ctl,
	output logic [ddl_pkg::DEPTH_W-1:0] depth
);
	import ddl_pkg::*;

	logic signed [DEPTH_W:0]          diff;
	logic signed [DEPTH_W+FRAC_W+1:0] prod;
	logic signed [DEPTH_W+1:0]        step;

	always_comb begin
		diff = $signed({1'b0, entry_b}) - $signed({1'b0, entry_a});
		prod = (DEPTH_W+FRAC_W+2)'(diff) * (DEPTH_W+FRAC_W+2)'($signed({1'b0, ctl.frac}));
		step = prod[DEPTH_W+FRAC_W+1:FRAC_W];
		priority if (ctl.hole) begin
			depth = '0;
		end else if (ctl.interp) begin
			depth = entry_a + step[DEPTH_W-1:0];
		end else begin
			depth = entry_a;
		end
	end
endmodule

FILE: src/disparity_to_depth_lookup_core.sv
// Pipeline: an accepted lookup beat passes the table read registers, then depth_q, to rsp.
// Throughput: one beat per cycle, writes and lookups alike, unless rsp stalls the output,
// set by the table memory with one write port and two read ports registered on acceptance.
// Reset clears the configuration registers and the pipeline valid flags at once;
// the table contents stay undefined until written, and a write beat yields no result.
module disparity_to_depth_lookup_core #(
	parameter int TABLE_DEPTH = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ddl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ddl_pkg::CFG_W-1:0]     cfg_wdata,
	ddl_req_if.sink                       req,
	ddl_rsp_if.source                     rsp
);
	import ddl_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic               round_nearest_q;
	logic [CFG_W-1:0]   table_entries_q;
	logic               adv;
	logic               accept;
	logic               wr_en;
	logic [AW-1:0]      raddr_a;
	logic [AW-1:0]      raddr_b;
	logic [DEPTH_W-1:0] rdata_a;
	logic [DEPTH_W-1:0] rdata_b;
	logic [DEPTH_W-1:0] depth;
	lookup_ctl_t        ctl;
	lookup_ctl_t        ctl_s1;
	logic               valid_s1;
	logic               out_valid_q;
	logic [DEPTH_W-1:0] depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_nearest_q <= 1'b0;
			table_entries_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROUND_NEAREST: round_nearest_q <= cfg_wdata[0];
				REG_TABLE_ENTRIES: table_entries_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign adv       = !out_valid_q || rsp.ready;
	assign req.ready = adv;
	assign accept    = req.valid && adv;
	assign wr_en     = accept && (req.req_type == REQ_WRITE)
		&& ((IDX_W)'(req.entry_index) < (IDX_W)'(TABLE_DEPTH));

	ddl_addr_gen #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.AW          (AW)
	) u_addr_gen (
		.round_nearest (round_nearest_q),
		.table_entries (table_entries_q),
		.disparity_q4  (req.disparity_q4),
		.raddr_a       (raddr_a),
		.raddr_b       (raddr_b),
		.ctl           (ctl)
	);

	ddl_table_ram #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_table_ram (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (AW'(req.entry_index)),
		.wdata   (req.entry_value),
		.re      (adv),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= accept && (req.req_type == REQ_LOOKUP);
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1  <= ctl;
			depth_q <= depth;
		end
	end

	ddl_interp u_interp (
		.entry_a (rdata_a),
		.entry_b (rdata_b),
		.ctl     (ctl_s1),
		.depth   (depth)
	);

	assign rsp.valid    = out_valid_q;
	assign rsp.depth_mm = depth_q;

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.req_type == REQ_WRITE)) |=> !valid_s1)
		else $error("write beat entered the result pipeline");

	a_lookup_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.req_type == REQ_LOOKUP)) |=> valid_s1)
		else $error("accepted lookup beat was dropped");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(ctl_s1)))
		else $error("stalled lookup lost its state");

	a_hole_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s1 && ctl_s1.hole) |=> (rsp.valid && (rsp.depth_mm == '0)))
		else $error("hole lookup produced a nonzero depth");
endmodule

FILE: test/depth_lookup_checker.sv
`timescale 1ns / 1ps

module depth_lookup_checker
	import ddl_pkg::*;
#(
	parameter int TABLE_DEPTH = 2048
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	ddl_req_if                   req,
	ddl_rsp_if                   rsp,
	output int                   mismatches,
	output int                   outstanding
);

	logic [DEPTH_W-1:0] depth_table [TABLE_DEPTH];
	logic               nearest_mode;
	logic [CFG_W-1:0]   entry_count;
	logic [DEPTH_W-1:0] depth_expected [$];
	logic [DEPTH_W-1:0] depth_due;

	function automatic logic [DEPTH_W-1:0] predict_depth(input logic [DISP_W-1:0] disp);
		int                n;
		int                idx;
		int                a;
		int                b;
		int                step;
		logic [FRAC_W-1:0] frac;
		n = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
		if (disp == '0 || n == 0) begin
			return '0;
		end
		if (nearest_mode) begin
			idx = (int'(disp) + int'(ROUND_HALF)) >> FRAC_W;
			if (idx >= n) begin
				idx = n - 1;
			end
			return depth_table[idx];
		end
		idx  = int'(disp) >> FRAC_W;
		frac = disp[FRAC_W-1:0];
		if (idx >= n - 1) begin
			return depth_table[n - 1];
		end
		a    = int'(depth_table[idx]);
		b    = int'(depth_table[idx + 1]);
		// The arithmetic shift rounds a falling slope towards minus infinity.
		step = ((b - a) * int'(frac)) >>> FRAC_W;
		return DEPTH_W'(a + step);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nearest_mode = 1'b0;
			entry_count  = '0;
			depth_expected.delete();
			foreach (depth_table[i]) begin
				depth_table[i] = '0;
			end
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_ROUND_NEAREST) begin
					nearest_mode = cfg_wdata[0];
				end else if (cfg_index == REG_TABLE_ENTRIES) begin
					entry_count = cfg_wdata;
				end
			end
			if (rsp.valid && rsp.ready) begin
				if (depth_expected.size() == 0) begin
					$error("depth_mm: expected no beat, actual %0d", rsp.depth_mm);
					mismatches++;
				end else begin
					depth_due = depth_expected.pop_front();
					if (rsp.depth_mm !== depth_due) begin
						$error("depth_mm: expected %0d, actual %0d", depth_due, rsp.depth_mm);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready) begin
				if (req.req_type == REQ_WRITE) begin
					if (req.entry_index < TABLE_DEPTH) begin
						depth_table[req.entry_index] = req.entry_value;
					end
				end else begin
					depth_expected.push_back(predict_depth(req.disparity_q4));
				end
			end
			outstanding = depth_expected.size();
		end
	end

endmodule

FILE: test/tb_disparity_to_depth_lookup_core.sv
`timescale 1ns / 1ps

module tb_disparity_to_depth_lookup_core;
	import ddl_pkg::*;

	localparam int TABLE_DEPTH  = 2048;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 900;
	localparam int LONG_HOLD    = 300;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	ddl_req_if req_ch ();
	ddl_rsp_if rsp_ch ();

	int mismatches;
	int outstanding;
	int send_gap_pct   = 0;
	int stall_pct      = 0;
	int hold_asked     = 0;
	int cycle_count    = 0;
	int active_entries = 0;
	bit written [TABLE_DEPTH];

	disparity_to_depth_lookup_core #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	depth_lookup_checker #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) depth_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** disparity_to_depth_lookup_core: FAILED **");
		$finish;
	end

	// The receiver counts a requested long hold itself while the sender keeps offering beats.
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen    = 0;
		hold_left    = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (hold_seen != hold_asked) begin
				hold_seen    = hold_asked;
				hold_left    = LONG_HOLD;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	task automatic send_beat(input logic kind, input logic [ENTRY_IDX_W-1:0] slot,
			input logic [DEPTH_W-1:0] value, input logic [DISP_W-1:0] disp);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.req_type     <= kind;
		req_ch.entry_index  <= slot;
		req_ch.entry_value  <= value;
		req_ch.disparity_q4 <= disp;
		do @(posedge clk); while (!req_ch.ready);
		if (kind == REQ_WRITE) begin
			written[slot] = 1'b1;
		end
	endtask

	task automatic put_entry(input int slot, input int value);
		send_beat(REQ_WRITE, ENTRY_IDX_W'(slot), DEPTH_W'(value), DISP_W'($urandom));
	endtask

	task automatic look_up(input int disp);
		send_beat(REQ_LOOKUP, ENTRY_IDX_W'($urandom), DEPTH_W'($urandom), DISP_W'(disp));
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		drain();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_table(input logic nearest, input int entries);
		write_reg(REG_ROUND_NEAREST, {(CFG_W-1)'($urandom), nearest});
		write_reg(REG_TABLE_ENTRIES, CFG_W'(entries));
		active_entries = (entries > TABLE_DEPTH) ? TABLE_DEPTH : entries;
	endtask

	// Both rounding modes are covered, as the block may read either the nearest entry or the pair of entries.
	function automatic bit reads_written(input int disp);
		int last;
		int lo;
		int near;
		if (disp == 0 || active_entries == 0) begin
			return 1'b1;
		end
		last = active_entries - 1;
		lo   = disp >> FRAC_W;
		near = (disp + int'(ROUND_HALF)) >> FRAC_W;
		if (near > last) begin
			near = last;
		end
		if (!written[near]) begin
			return 1'b0;
		end
		if (lo >= last) begin
			return written[last];
		end
		return written[lo] && written[lo + 1];
	endfunction

	initial begin
		int  items_done;
		int  phase;
		int  entries;
		int  fill_top;
		int  span;
		int  disp;
		int  cand;
		int  hi;
		bit  found;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_wdata           = '0;
		req_ch.valid        = 1'b0;
		req_ch.req_type     = REQ_WRITE;
		req_ch.entry_index  = '0;
		req_ch.entry_value  = '0;
		req_ch.disparity_q4 = '0;
		items_done          = 0;
		phase               = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put_entry(0, 5000);
		put_entry(1, 4000);
		put_entry(2, 4000);
		put_entry(3, 65535);
		put_entry(2046, 0);
		put_entry(2047, 65535);
		look_up(0);
		look_up(16'hFFFF);
		set_table(1'b0, 4);
		look_up(0);
		look_up(1);
		look_up(24);
		look_up(47);
		look_up(48);
		look_up(16'hFFFF);
		set_table(1'b0, 1);
		look_up(40);
		look_up(16'hFFFF);
		set_table(1'b1, 4);
		look_up(7);
		look_up(8);
		look_up(16'h37);
		look_up(16'hFFFF);
		set_table(1'b0, 4095);
		look_up(2046 * 16 + 5);
		look_up(16'hFFFF);
		set_table(1'b1, 2048);
		look_up(2046 * 16 + 9);
		look_up(16'hFFFF);
		set_table(1'b1, 0);
		look_up(16'h20);

		while (items_done < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0:       entries = 0;
				1, 2, 3: entries = $urandom_range(1, 8);
				8:       entries = TABLE_DEPTH;
				9:       entries = $urandom_range(TABLE_DEPTH + 1, 4095);
				default: entries = $urandom_range(9, 64);
			endcase
			set_table($urandom_range(0, 1), entries);
			case (phase % 4)
				0: begin
					send_gap_pct = 0;
					stall_pct    = 0;
				end
				1: begin
					send_gap_pct = 47;
					stall_pct    = 0;
				end
				2: begin
					send_gap_pct = 0;
					stall_pct    = 47;
				end
				default: begin
					send_gap_pct = 36;
					stall_pct    = 36;
				end
			endcase
			fill_top = (active_entries > 64) ? 32 : active_entries;
			for (int i = 0; i < fill_top; i++) begin
				if (!written[i]) begin
					put_entry(i, $urandom);
				end
			end
			if (active_entries > 64) begin
				for (int i = active_entries - 3; i < active_entries; i++) begin
					if (!written[i]) begin
						put_entry(i, $urandom);
					end
				end
			end
			if (phase % 3 == 1) begin
				hold_asked++;
			end
			span = $urandom_range(60, 120);
			repeat (span) begin
				if ($urandom_range(0, 59) == 0) begin
					drain();
				end
				if ($urandom_range(0, 99) < 35) begin
					if ($urandom_range(0, 99) < 80) begin
						put_entry($urandom_range(0, ((fill_top > 2) ? fill_top : 2) - 1),
							$urandom);
					end else begin
						put_entry($urandom_range(0, TABLE_DEPTH - 1), $urandom);
					end
				end else begin
					found = 1'b0;
					disp  = 0;
					hi    = active_entries * 16 + 16;
					if (hi > 65535) begin
						hi = 65535;
					end
					for (int t = 0; t < 8 && !found; t++) begin
						case ($urandom_range(0, 9))
							0:       cand = 0;
							1:       cand = $urandom_range(0, 65535);
							2:       cand = (active_entries - 1) * 16 + $urandom_range(0, 31);
							default: cand = $urandom_range(1, hi);
						endcase
						if (cand < 0) begin
							cand = 0;
						end
						if (cand > 65535) begin
							cand = 65535;
						end
						if (reads_written(cand)) begin
							disp  = cand;
							found = 1'b1;
						end
					end
					if (!found) begin
						disp = $urandom_range(1, 15);
					end
					look_up(disp);
				end
				items_done++;
			end
			phase++;
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("** disparity_to_depth_lookup_core: PASSED **");
		end else begin
			$display("** disparity_to_depth_lookup_core: FAILED **");
		end
		$finish;
	end

endmodule

FILE: disparity_to_depth_lookup_core.f
src/ddl_pkg.sv
src/ddl_ifs.sv
src/ddl_table_ram.sv
src/ddl_addr_gen.sv
src/ddl_interp.sv
src/disparity_to_depth_lookup_core.sv
test/depth_lookup_checker.sv
test/tb_disparity_to_depth_lookup_core.sv
